FILE: src/bsc_pkg.sv
`timescale 1ns / 1ps

package bsc_pkg;

  // What the back end has to do for one accepted control point.
  typedef enum logic [1:0] {
    OP_PASS     = 2'd0,  // emit the control point itself
    OP_MID      = 2'd1,  // emit the midpoint of the newer point and this one
    OP_INTERIOR = 2'd2   // weighted point, midpoint, and the point itself if final
  } op_t;

  // Control word carried through the queue alongside the coordinates.
  typedef struct packed {
    op_t  op;
    logic last;
  } ctl_t;

  localparam int CTL_W = $bits(ctl_t);

  // Position within the current curve, as seen by the front end.
  typedef enum logic [2:0] {
    ST_START = 3'b001,
    ST_ONE   = 3'b010,
    ST_MANY  = 3'b100
  } curve_state_t;

  // Queue depth between the front and back ends.
  localparam int QUEUE_DEPTH = 2;

endpackage

FILE: src/bsc_front.sv
`timescale 1ns / 1ps

module bsc_front #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic signed [COORD_WIDTH-1:0] cur_x,
  input  logic signed [COORD_WIDTH-1:0] cur_y,
  input  logic                          cur_last,
  output bsc_pkg::ctl_t                 ctl,
  output logic signed [COORD_WIDTH-1:0] newer_x,
  output logic signed [COORD_WIDTH-1:0] newer_y,
  output logic signed [COORD_WIDTH-1:0] older_x,
  output logic signed [COORD_WIDTH-1:0] older_y
);

  bsc_pkg::curve_state_t state_r, state_nxt;
  logic signed [COORD_WIDTH-1:0] newer_x_r, newer_y_r, older_x_r, older_y_r;
  logic take_point;
  logic shift_points;

  always_comb begin
    ctl          = '{op: bsc_pkg::OP_PASS, last: cur_last};
    state_nxt    = state_r;
    take_point   = 1'b0;
    shift_points = 1'b0;
    unique case (state_r)
      bsc_pkg::ST_ONE: begin
        if (cur_last) begin
          ctl       = '{op: bsc_pkg::OP_PASS, last: 1'b1};
          state_nxt = bsc_pkg::ST_START;
        end else begin
          ctl          = '{op: bsc_pkg::OP_MID, last: 1'b0};
          shift_points = 1'b1;
          state_nxt    = bsc_pkg::ST_MANY;
        end
      end
      bsc_pkg::ST_MANY: begin
        ctl = '{op: bsc_pkg::OP_INTERIOR, last: cur_last};
        if (cur_last) begin
          state_nxt = bsc_pkg::ST_START;
        end else begin
          shift_points = 1'b1;
        end
      end
      default: begin
        // Start of a curve: a lone final point leaves no trace.
        if (!cur_last) begin
          take_point = 1'b1;
          state_nxt  = bsc_pkg::ST_ONE;
        end else begin
          state_nxt = bsc_pkg::ST_START;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bsc_pkg::ST_START;
      newer_x_r <= '0;
      newer_y_r <= '0;
      older_x_r <= '0;
      older_y_r <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
      if (take_point || shift_points) begin
        newer_x_r <= cur_x;
        newer_y_r <= cur_y;
      end
      if (shift_points) begin
        older_x_r <= newer_x_r;
        older_y_r <= newer_y_r;
      end
    end
  end

  assign newer_x = newer_x_r;
  assign newer_y = newer_y_r;
  assign older_x = older_x_r;
  assign older_y = older_y_r;

endmodule

FILE: src/bsc_queue.sv
`timescale 1ns / 1ps

module bsc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             empty,
  output logic             full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  logic [WIDTH-1:0] slots_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;

  assign empty     = (count_r == '0);
  assign full      = (count_r == CW'(DEPTH));
  assign head_data = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

FILE: src/bsc_back.sv
`timescale 1ns / 1ps

module bsc_back #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          head_valid,
  input  bsc_pkg::ctl_t                 ctl,
  input  logic signed [COORD_WIDTH-1:0] cur_x,
  input  logic signed [COORD_WIDTH-1:0] cur_y,
  input  logic signed [COORD_WIDTH-1:0] newer_x,
  input  logic signed [COORD_WIDTH-1:0] newer_y,
  input  logic signed [COORD_WIDTH-1:0] older_x,
  input  logic signed [COORD_WIDTH-1:0] older_y,
  output logic                          pop,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic                          out_last
);

  localparam int SW = COORD_WIDTH + 3;

  logic [1:0] step_r, step_nxt, final_step;
  logic       out_valid_r, out_valid_nxt;
  logic signed [COORD_WIDTH-1:0] out_x_r, out_y_r;
  logic       out_last_r;
  logic       load;

  logic signed [COORD_WIDTH:0]   mid_sum_x, mid_sum_y;
  logic signed [COORD_WIDTH-1:0] mid_x, mid_y;
  logic signed [SW-1:0]          wsum_x, wsum_y;
  logic signed [COORD_WIDTH-1:0] wgt_x, wgt_y;
  logic signed [COORD_WIDTH-1:0] res_x, res_y;
  logic                          res_last;

  // Midpoint, rounded down by the arithmetic shift.
  assign mid_sum_x = {newer_x[COORD_WIDTH-1], newer_x} + {cur_x[COORD_WIDTH-1], cur_x};
  assign mid_sum_y = {newer_y[COORD_WIDTH-1], newer_y} + {cur_y[COORD_WIDTH-1], cur_y};
  assign mid_x     = COORD_WIDTH'(mid_sum_x >>> 1);
  assign mid_y     = COORD_WIDTH'(mid_sum_y >>> 1);

  // Weighted point (older + 6*newer + cur) / 8, with 6*newer as 4*newer + 2*newer.
  assign wsum_x = {{3{older_x[COORD_WIDTH-1]}}, older_x}
                + {newer_x[COORD_WIDTH-1], newer_x, 2'b00}
                + {{2{newer_x[COORD_WIDTH-1]}}, newer_x, 1'b0}
                + {{3{cur_x[COORD_WIDTH-1]}}, cur_x};
  assign wsum_y = {{3{older_y[COORD_WIDTH-1]}}, older_y}
                + {newer_y[COORD_WIDTH-1], newer_y, 2'b00}
                + {{2{newer_y[COORD_WIDTH-1]}}, newer_y, 1'b0}
                + {{3{cur_y[COORD_WIDTH-1]}}, cur_y};
  assign wgt_x = COORD_WIDTH'(wsum_x >>> 3);
  assign wgt_y = COORD_WIDTH'(wsum_y >>> 3);

  always_comb begin
    res_x      = cur_x;
    res_y      = cur_y;
    res_last   = ctl.last;
    final_step = 2'd0;
    unique case (ctl.op)
      bsc_pkg::OP_MID: begin
        res_x    = mid_x;
        res_y    = mid_y;
        res_last = 1'b0;
      end
      bsc_pkg::OP_INTERIOR: begin
        final_step = ctl.last ? 2'd2 : 2'd1;
        case (step_r)
          2'd0: begin
            res_x    = wgt_x;
            res_y    = wgt_y;
            res_last = 1'b0;
          end
          2'd1: begin
            res_x    = mid_x;
            res_y    = mid_y;
            res_last = 1'b0;
          end
          default: begin
            res_last = 1'b1;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  assign load = head_valid && (!out_valid_r || !out_stall);
  assign pop  = load && (step_r == final_step);

  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load) begin
      step_nxt      = pop ? 2'd0 : step_r + 2'd1;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_x_r    <= res_x;
      out_y_r    <= res_y;
      out_last_r <= res_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_last  = out_last_r;

endmodule

FILE: src/bspline_curve_subdivision.sv
`timescale 1ns / 1ps

// One pass of cubic B-spline subdivision over a stream of control points, with the end
// points of every curve kept. Points arrive one request at a time on the in_ channel, with
// in_last_in set on the final point of each curve; the subdivided points leave on the out_
// channel, with out_last_out set on the final point. A curve's first point is passed through,
// each following point yields the midpoint to its predecessor, every interior point adds the
// weighted point (prev + 6*cur + next)/8, and the final point is emitted at the end. A
// one-point curve gives that point and a two-point curve gives both points. Coordinates are
// two's complement, COORD_WIDTH bits; halving and eighths round towards minus infinity. The
// front end tracks the position in the curve and writes a two-entry queue; the back end reads
// the queue and, unless out_stall is high, gives one result per clock to the output register.
// An interior point gives the weighted point and then the midpoint (and then the point itself
// for the final point of a curve), every other point one result; the queue entry is retired
// with the last of them. When the back end is idle, an accepted request is written into the
// queue and its first result is then loaded into the output register. in_stall is high
// exactly while the queue is full, so the input is still accepted while a finished result
// waits at the output, until the queue is full.

module bspline_curve_subdivision #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_x_in,
  input  logic signed [COORD_WIDTH-1:0] in_y_in,
  input  logic                          in_last_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_x_out,
  output logic signed [COORD_WIDTH-1:0] out_y_out,
  output logic                          out_last_out
);

  // A queue entry holds the control word, the new point and the two points before it.
  localparam int QW = bsc_pkg::CTL_W + 6 * COORD_WIDTH;

  logic                          accept;
  logic                          q_full, q_empty, q_pop;
  bsc_pkg::ctl_t                 push_ctl, head_ctl;
  logic signed [COORD_WIDTH-1:0] f_newer_x, f_newer_y, f_older_x, f_older_y;
  logic signed [COORD_WIDTH-1:0] h_cur_x, h_cur_y, h_newer_x, h_newer_y;
  logic signed [COORD_WIDTH-1:0] h_older_x, h_older_y;
  logic [QW-1:0]                 push_data, head_data;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  bsc_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .cur_x    (in_x_in),
    .cur_y    (in_y_in),
    .cur_last (in_last_in),
    .ctl      (push_ctl),
    .newer_x  (f_newer_x),
    .newer_y  (f_newer_y),
    .older_x  (f_older_x),
    .older_y  (f_older_y)
  );

  assign push_data = {push_ctl, in_x_in, in_y_in, f_newer_x, f_newer_y, f_older_x, f_older_y};

  bsc_queue #(
    .WIDTH(QW),
    .DEPTH(bsc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (push_data),
    .pop       (q_pop),
    .head_data (head_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  assign {head_ctl, h_cur_x, h_cur_y, h_newer_x, h_newer_y, h_older_x, h_older_y} = head_data;

  bsc_back #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (!q_empty),
    .ctl        (head_ctl),
    .cur_x      (h_cur_x),
    .cur_y      (h_cur_y),
    .newer_x    (h_newer_x),
    .newer_y    (h_newer_y),
    .older_x    (h_older_x),
    .older_y    (h_older_y),
    .pop        (q_pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_x      (out_x_out),
    .out_y      (out_y_out),
    .out_last   (out_last_out)
  );

  // The back end only retires an entry that is actually in the queue.
  a_pop_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  // A full queue stays full until the back end retires an entry.
  a_full_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (q_full && !q_pop) |=> q_full)
    else $error("queue lost an entry without a pop");

  // With one entry waiting, a further request and no retirement fill the two-entry queue.
  a_fill : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !q_pop && !q_empty) |=> q_full)
    else $error("queue failed to fill");

  // A retirement always leaves a result in the output register.
  a_pop_loads : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid)
    else $error("entry retired without a result");

endmodule
